### rtl/ict_pkg.sv
// Shared constants and types for the incremental component tracker.
package ict_pkg;

    localparam int NODE_SLOTS_DEF      = 1024;
    localparam int COMPONENT_SLOTS_DEF = 256;

    // Fixed widths of the beat fields.
    localparam int NODE_IN_W  = 10;
    localparam int COMP_OUT_W = 9;
    localparam int COUNT_W    = 9;
    localparam int LABEL_W    = 11;

    localparam logic [LABEL_W-1:0] LABEL_MAX = 11'd2047;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Control of the merged-list ring.
    typedef struct packed {
        logic shift;
        logic append;
    } chain_ctl_t;

endpackage

### rtl/incremental_component_tracker_unit.sv
// Incremental connected-component tracker: top level with sequencer, stores and result register.
//
// The block labels nodes of a growing graph with component ids and joins
// components when an edge links two labelled nodes. Each input beat carries
// a command (add edge or query) and two node ids, and produces exactly one
// output beat. After reset the block runs a clearing pass over all
// max(NODE_SLOTS, COMPONENT_SLOTS) entries of the node and group stores,
// during which in_stall stays high. An item is worked on one at a time: node
// ids are reduced modulo NODE_SLOTS by a reciprocal multiplication and a
// subtraction, followed by a node lookup, a group lookup and a decision. A
// query, or an edge that needs no fresh id and no join, then goes to the
// result; an edge that hands out a fresh id first writes it for the second
// node. An edge that joins two components also rotates the merged-list ring
// once around all COMPONENT_SLOTS cells, relabeling group marks on the way,
// and then appends up to two ids. The sequencer returns to idle at the clock
// edge that loads the result, and only then takes the next beat. A result
// still stalled in the output register holds the sequencer in its last state.
module incremental_component_tracker_unit #(
    parameter int NODE_SLOTS      = ict_pkg::NODE_SLOTS_DEF,
    parameter int COMPONENT_SLOTS = ict_pkg::COMPONENT_SLOTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [ict_pkg::NODE_IN_W-1:0]         node_a,
    input  logic [ict_pkg::NODE_IN_W-1:0]         node_b,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  status,
    output logic                                  connected,
    output logic signed [ict_pkg::COMP_OUT_W-1:0] comp_of_a,
    output logic signed [ict_pkg::COMP_OUT_W-1:0] comp_of_b,
    output logic [ict_pkg::COUNT_W-1:0]           merged_count,
    output logic [ict_pkg::LABEL_W-1:0]           labelled_count
);
    import ict_pkg::*;

    localparam int NIW         = $clog2(NODE_SLOTS);
    localparam int CW          = $clog2(COMPONENT_SLOTS);
    localparam int CLEAR_SLOTS = (NODE_SLOTS > COMPONENT_SLOTS) ? NODE_SLOTS : COMPONENT_SLOTS;
    localparam int CLRW        = $clog2(CLEAR_SLOTS);

    // Reciprocal of NODE_SLOTS, exact for every node id of NODE_IN_W bits.
    localparam int     RSH  = NODE_IN_W + $clog2(NODE_SLOTS);
    localparam int     RMW  = NODE_IN_W + 2;
    localparam longint RMUL = ((longint'(1) << RSH) + longint'(NODE_SLOTS) - 1) /
                              longint'(NODE_SLOTS);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_REDUCE = 4'd2;
    localparam logic [3:0] ST_LOOK   = 4'd3;
    localparam logic [3:0] ST_GLOOK  = 4'd4;
    localparam logic [3:0] ST_DECIDE = 4'd5;
    localparam logic [3:0] ST_WRB    = 4'd6;
    localparam logic [3:0] ST_JOINB  = 4'd7;
    localparam logic [3:0] ST_WALK   = 4'd8;
    localparam logic [3:0] ST_APP1   = 4'd9;
    localparam logic [3:0] ST_APP2   = 4'd10;
    localparam logic [3:0] ST_FINISH = 4'd11;
    localparam logic [3:0] ST_RSUB   = 4'd12;

    // Component id zero is never handed out, so zero encodes "no component"
    // in both stores and in the ring.

    // Control state.
    logic [3:0]        state_reg, state_next;
    logic [CLRW-1:0]   clr_reg, clr_next;
    logic [CW-1:0]     last_reg, last_next;
    logic [LABEL_W-1:0] label_reg, label_next;
    logic [CW:0]       total_reg, total_next;
    logic [CW:0]       walk_reg, walk_next;
    logic              have1_reg, have1_next;
    logic              have2_reg, have2_next;
    logic              out_valid_reg, out_valid_next;

    // Item payload.
    logic                 cmd_reg, cmd_next;
    logic [NODE_IN_W-1:0] ra_reg, ra_next;
    logic [NODE_IN_W-1:0] rb_reg, rb_next;
    logic [NODE_IN_W-1:0] qa_reg, qa_next;
    logic [NODE_IN_W-1:0] qb_reg, qb_next;
    logic [CW-1:0]        ca_reg, ca_next;
    logic [CW-1:0]        cb_reg, cb_next;
    logic [CW-1:0]        common_reg, common_next;
    logic [CW-1:0]        old_reg, old_next;
    logic                 status_reg, status_next;
    logic                 conn_reg, conn_next;

    // Result register.
    logic                  res_status_reg;
    logic                  res_conn_reg;
    logic [COMP_OUT_W-1:0] res_ca_reg;
    logic [COMP_OUT_W-1:0] res_cb_reg;
    logic [COUNT_W-1:0]    res_merged_reg;
    logic [LABEL_W-1:0]    res_label_reg;
    logic                  out_load;

    // Stores.
    logic [CW-1:0] node_mem  [NODE_SLOTS];
    logic [CW-1:0] group_mem [COMPONENT_SLOTS];
    logic [CW-1:0] nrd_a, nrd_b, grd_a, grd_b;
    logic          nwe, gwe;
    logic [NIW-1:0] nwaddr;
    logic [CW-1:0]  nwdata, gwaddr, gwdata;

    // Ring.
    chain_ctl_t     chain_ctl;
    logic [CW-1:0]  app_idx;
    logic [2*CW-1:0] app_data, tail_in, head_out;
    logic [CW-1:0]  head_id, head_grp;

    // Modulo reduction: quotient estimate, then the product to subtract.
    logic [NODE_IN_W+RMW-1:0] prod_a, prod_b;
    logic [31:0]              qn_a, qn_b;

    logic       accept;
    logic       conn_now;
    logic [CW-1:0] new_id;
    logic          pool_full;
    logic          head_valid, hit1, hit2, relabel;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign head_id  = head_out[2*CW-1:CW];
    assign head_grp = head_out[CW-1:0];

    assign prod_a    = ra_reg * RMW'(RMUL);
    assign prod_b    = rb_reg * RMW'(RMUL);
    assign qn_a      = 32'(qa_reg) * 32'(NODE_SLOTS);
    assign qn_b      = 32'(qb_reg) * 32'(NODE_SLOTS);
    assign new_id    = last_reg + 1'b1;
    assign pool_full = (({1'b0, last_reg} + 1'b1) >= (CW+1)'(COMPONENT_SLOTS));

    // Two labelled components are connected when the ids match or they share
    // a nonzero group mark.
    assign conn_now = (ca_reg != '0) && (cb_reg != '0) &&
                      ((ca_reg == cb_reg) || ((grd_a == grd_b) && (grd_a != '0)));

    assign head_valid = (walk_reg < total_reg);
    assign hit1       = (head_id == ca_reg);
    assign hit2       = (head_id == cb_reg);
    assign relabel    = head_valid && (old_reg != '0) && (head_grp == old_reg) && !hit1 && !hit2;

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (nwe)
        begin
            node_mem[nwaddr] <= nwdata;
        end
        nrd_a <= node_mem[NIW'(ra_reg)];
        nrd_b <= node_mem[NIW'(rb_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (gwe)
        begin
            group_mem[gwaddr] <= gwdata;
        end
        grd_a <= group_mem[nrd_a];
        grd_b <= group_mem[nrd_b];
    end

    ict_chain #(
        .SLOTS(COMPONENT_SLOTS),
        .W    (2*CW)
    ) u_chain (
        .clk     (clk),
        .ctl     (chain_ctl),
        .app_idx (app_idx),
        .app_data(app_data),
        .tail_in (tail_in),
        .head_out(head_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        last_next      = last_reg;
        label_next     = label_reg;
        total_next     = total_reg;
        walk_next      = walk_reg;
        have1_next     = have1_reg;
        have2_next     = have2_reg;
        cmd_next       = cmd_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        common_next    = common_reg;
        old_next       = old_reg;
        status_next    = status_reg;
        conn_next      = conn_reg;
        nwe            = 1'b0;
        nwaddr         = NIW'(ra_reg);
        nwdata         = '0;
        gwe            = 1'b0;
        gwaddr         = ca_reg;
        gwdata         = common_reg;
        chain_ctl      = '0;
        app_idx        = CW'(total_reg);
        app_data       = {ca_reg, common_reg};
        tail_in        = head_out;

        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                nwe    = (32'(clr_reg) < 32'(NODE_SLOTS));
                nwaddr = NIW'(clr_reg);
                nwdata = '0;
                gwe    = (32'(clr_reg) < 32'(COMPONENT_SLOTS));
                gwaddr = CW'(clr_reg);
                gwdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLRW'(CLEAR_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    ra_next     = node_a;
                    rb_next     = node_b;
                    status_next = STATUS_OK;
                    conn_next   = 1'b0;
                    state_next  = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // Quotient of each node id by NODE_SLOTS.
                qa_next    = NODE_IN_W'(prod_a >> RSH);
                qb_next    = NODE_IN_W'(prod_b >> RSH);
                state_next = ST_RSUB;
            end
            ST_RSUB:
            begin
                ra_next    = ra_reg - NODE_IN_W'(qn_a);
                rb_next    = rb_reg - NODE_IN_W'(qn_b);
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                state_next = ST_GLOOK;
            end
            ST_GLOOK:
            begin
                ca_next    = nrd_a;
                cb_next    = nrd_b;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_FINISH;
                if (cmd_reg == CMD_QUERY)
                begin
                    conn_next = conn_now;
                end
                else if ((ca_reg == '0) && (cb_reg == '0))
                begin
                    if (pool_full)
                    begin
                        status_next = STATUS_FULL;
                        conn_next   = 1'b0;
                    end
                    else
                    begin
                        last_next  = new_id;
                        ca_next    = new_id;
                        cb_next    = new_id;
                        nwe        = 1'b1;
                        nwaddr     = NIW'(ra_reg);
                        nwdata     = new_id;
                        label_next = (label_reg < LABEL_MAX) ? label_reg + 1'b1 : label_reg;
                        conn_next  = 1'b1;
                        state_next = ST_WRB;
                    end
                end
                else if (ca_reg == '0)
                begin
                    ca_next    = cb_reg;
                    nwe        = 1'b1;
                    nwaddr     = NIW'(ra_reg);
                    nwdata     = cb_reg;
                    label_next = (label_reg < LABEL_MAX) ? label_reg + 1'b1 : label_reg;
                    conn_next  = 1'b1;
                end
                else if (cb_reg == '0)
                begin
                    cb_next    = ca_reg;
                    nwe        = 1'b1;
                    nwaddr     = NIW'(rb_reg);
                    nwdata     = ca_reg;
                    label_next = (label_reg < LABEL_MAX) ? label_reg + 1'b1 : label_reg;
                    conn_next  = 1'b1;
                end
                else if (conn_now)
                begin
                    conn_next = 1'b1;
                end
                else
                begin
                    // Join: the first component's mark, or its own id, becomes
                    // the common mark; the second one's old mark is remembered.
                    common_next = (grd_a != '0) ? grd_a : ca_reg;
                    old_next    = grd_b;
                    gwe         = 1'b1;
                    gwaddr      = ca_reg;
                    gwdata      = (grd_a != '0) ? grd_a : ca_reg;
                    conn_next   = 1'b1;
                    state_next  = ST_JOINB;
                end
            end
            ST_WRB:
            begin
                nwe        = 1'b1;
                nwaddr     = NIW'(rb_reg);
                nwdata     = cb_reg;
                label_next = (label_reg < LABEL_MAX) ? label_reg + 1'b1 : label_reg;
                state_next = ST_FINISH;
            end
            ST_JOINB:
            begin
                gwe        = 1'b1;
                gwaddr     = cb_reg;
                gwdata     = common_reg;
                walk_next  = '0;
                have1_next = 1'b0;
                have2_next = 1'b0;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // The ring turns once; each live entry is checked at the head.
                chain_ctl.shift = 1'b1;
                if (head_valid && (hit1 || hit2 || relabel))
                begin
                    tail_in = {head_id, common_reg};
                end
                if (relabel)
                begin
                    gwe    = 1'b1;
                    gwaddr = head_id;
                    gwdata = common_reg;
                end
                have1_next = have1_reg || (head_valid && hit1);
                have2_next = have2_reg || (head_valid && hit2);
                walk_next  = walk_reg + 1'b1;
                if (walk_reg == (CW+1)'(COMPONENT_SLOTS - 1))
                begin
                    state_next = ST_APP1;
                end
            end
            ST_APP1:
            begin
                if (!have1_reg && (total_reg < (CW+1)'(COMPONENT_SLOTS)))
                begin
                    chain_ctl.append = 1'b1;
                    app_data         = {ca_reg, common_reg};
                    total_next       = total_reg + 1'b1;
                end
                state_next = ST_APP2;
            end
            ST_APP2:
            begin
                if (!have2_reg && (total_reg < (CW+1)'(COMPONENT_SLOTS)))
                begin
                    chain_ctl.append = 1'b1;
                    app_data         = {cb_reg, common_reg};
                    total_next       = total_reg + 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            last_reg      <= '0;
            label_reg     <= '0;
            total_reg     <= '0;
            walk_reg      <= '0;
            have1_reg     <= 1'b0;
            have2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            last_reg      <= last_next;
            label_reg     <= label_next;
            total_reg     <= total_next;
            walk_reg      <= walk_next;
            have1_reg     <= have1_next;
            have2_reg     <= have2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        common_reg <= common_next;
        old_reg    <= old_next;
        status_reg <= status_next;
        conn_reg   <= conn_next;
        if (out_load)
        begin
            res_status_reg <= status_reg;
            res_conn_reg   <= conn_reg;
            res_ca_reg     <= (ca_reg == '0) ? '1 : COMP_OUT_W'(ca_reg);
            res_cb_reg     <= (cb_reg == '0) ? '1 : COMP_OUT_W'(cb_reg);
            res_merged_reg <= COUNT_W'(total_reg);
            res_label_reg  <= label_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = res_status_reg;
    assign connected      = res_conn_reg;
    assign comp_of_a      = res_ca_reg;
    assign comp_of_b      = res_cb_reg;
    assign merged_count   = res_merged_reg;
    assign labelled_count = res_label_reg;

endmodule

### rtl/ict_cell.sv
// One cell of the merged-list ring: holds a component id and its group mark.
module ict_cell #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         shift,
    input  logic         load,
    input  logic [W-1:0] d_shift,
    input  logic [W-1:0] d_load,
    output logic [W-1:0] q
);

    logic [W-1:0] q_reg;

    // A shift always wins; an append never coincides with a rotation.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d_shift;
        end
        else if (load)
        begin
            q_reg <= d_load;
        end
    end

    assign q = q_reg;

endmodule

### rtl/ict_chain.sv
// Ring of cells that holds the merged component list and rotates it one place a cycle while shift is set.
module ict_chain #(
    parameter int SLOTS = 256,
    parameter int W     = 16
) (
    input  logic                      clk,
    input  ict_pkg::chain_ctl_t       ctl,
    input  logic [$clog2(SLOTS)-1:0]  app_idx,
    input  logic [W-1:0]              app_data,
    input  logic [W-1:0]              tail_in,
    output logic [W-1:0]              head_out
);
    import ict_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic [W-1:0] q [SLOTS+1];

    // The element leaving the head comes back, possibly updated, at the tail.
    assign q[SLOTS] = tail_in;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        ict_cell #(
            .W(W)
        ) u_cell (
            .clk    (clk),
            .shift  (ctl.shift),
            .load   (ctl.append && (app_idx == IW'(i))),
            .d_shift(q[i+1]),
            .d_load (app_data),
            .q      (q[i])
        );
    end

    assign head_out = q[0];

endmodule

### rtl/ict_checker.sv
// Port-level checker for the component tracker and its bind to the top level.
module ict_props (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  command,
    input logic [ict_pkg::NODE_IN_W-1:0]         node_a,
    input logic [ict_pkg::NODE_IN_W-1:0]         node_b,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  status,
    input logic                                  connected,
    input logic signed [ict_pkg::COMP_OUT_W-1:0] comp_of_a,
    input logic signed [ict_pkg::COMP_OUT_W-1:0] comp_of_b,
    input logic [ict_pkg::COUNT_W-1:0]           merged_count,
    input logic [ict_pkg::LABEL_W-1:0]           labelled_count
);
    import ict_pkg::*;

    // An accepted beat keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // A full pool leaves both nodes unlabelled, so they cannot be connected.
    a_full_not_connected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_FULL) |-> !connected)
        else $error("connected reported with exhausted pool");

    // Connected nodes always carry component ids.
    a_connected_labelled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && connected |-> (comp_of_a != '1) && (comp_of_b != '1))
        else $error("connected reported for unlabelled node");

    // A stalled output beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(connected) &&
            $stable(comp_of_a) && $stable(comp_of_b) && $stable(merged_count) &&
            $stable(labelled_count))
        else $error("stalled output beat dropped or changed");

    // A stalled input beat stays valid and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(command) && $stable(node_a) &&
            $stable(node_b))
        else $error("stalled input beat dropped or changed");

endmodule

bind incremental_component_tracker_unit ict_props u_ict_props (.*);

### tb/ict_checker.sv
// Checker for the component tracker: tracks its own copy of the graph state and compares each result beat.
`timescale 1ns / 1ps

module ict_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  command,
    input  logic [ict_pkg::NODE_IN_W-1:0]         node_a,
    input  logic [ict_pkg::NODE_IN_W-1:0]         node_b,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic                                  status,
    input  logic                                  connected,
    input  logic signed [ict_pkg::COMP_OUT_W-1:0] comp_of_a,
    input  logic signed [ict_pkg::COMP_OUT_W-1:0] comp_of_b,
    input  logic [ict_pkg::COUNT_W-1:0]           merged_count,
    input  logic [ict_pkg::LABEL_W-1:0]           labelled_count,
    output int                                    fail_count,
    output int                                    pending
);
    import ict_pkg::*;

    localparam int NODES = NODE_SLOTS_DEF;
    localparam int COMPS = COMPONENT_SLOTS_DEF;
    localparam logic signed [COMP_OUT_W-1:0] NO_COMP = -9'sd1;

    typedef logic signed [COMP_OUT_W-1:0] comp_id_t;

    typedef struct {
        logic               status;
        logic               connected;
        comp_id_t           comp_a;
        comp_id_t           comp_b;
        logic [COUNT_W-1:0] merged;
        logic [LABEL_W-1:0] labels;
    } tracker_result_t;

    tracker_result_t expected_results[$];

    comp_id_t   node_comp  [NODES];
    comp_id_t   comp_group [COMPS];
    logic [7:0] merged_ids [COMPS];
    int         merged_total;
    int         last_comp;
    int         label_total;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Two components are linked when equal or when they share a group mark.
    function automatic logic comps_linked(input comp_id_t c1, input comp_id_t c2);
        comp_id_t g1;
        comp_id_t g2;
        if (c1 == NO_COMP || c2 == NO_COMP) return 1'b0;
        if (c1 == c2) return 1'b1;
        g1 = comp_group[c1[7:0]];
        g2 = comp_group[c2[7:0]];
        if (g1 == NO_COMP && g2 == NO_COMP) return 1'b0;
        return g1 == g2;
    endfunction

    task automatic label_node(input int node, input comp_id_t id);
        node_comp[node] = id;
        if (label_total < int'(LABEL_MAX)) label_total++;
    endtask

    task automatic join_comps(input comp_id_t c1, input comp_id_t c2);
        comp_id_t   common;
        comp_id_t   old_mark;
        logic       have1;
        logic       have2;
        logic [7:0] m;
        have1 = 1'b0;
        have2 = 1'b0;
        common = comp_group[c1[7:0]];
        if (common == NO_COMP)
        begin
            comp_group[c1[7:0]] = c1;
            common = c1;
        end
        old_mark = comp_group[c2[7:0]];
        comp_group[c2[7:0]] = common;
        for (int i = 0; i < merged_total; i++)
        begin
            m = merged_ids[i];
            if (old_mark != NO_COMP && comp_group[m] == old_mark) comp_group[m] = common;
            if (m == c1[7:0]) have1 = 1'b1;
            if (m == c2[7:0]) have2 = 1'b1;
        end
        if (!have1 && merged_total < COMPS) merged_ids[merged_total++] = c1[7:0];
        if (!have2 && merged_total < COMPS) merged_ids[merged_total++] = c2[7:0];
    endtask

    task automatic track_step(input logic cmd, input int a, input int b,
                              output tracker_result_t res);
        comp_id_t ca;
        comp_id_t cb;
        res.status = STATUS_OK;
        ca = node_comp[a];
        cb = node_comp[b];
        if (cmd == CMD_ADD)
        begin
            if (ca == NO_COMP && cb == NO_COMP)
            begin
                if (last_comp + 1 >= COMPS)
                    res.status = STATUS_FULL;
                else
                begin
                    last_comp++;
                    label_node(a, comp_id_t'(last_comp));
                    label_node(b, comp_id_t'(last_comp));
                end
            end
            else if (ca == NO_COMP)
                label_node(a, cb);
            else if (cb == NO_COMP)
                label_node(b, ca);
            else if (!comps_linked(ca, cb))
                join_comps(ca, cb);
            ca = node_comp[a];
            cb = node_comp[b];
        end
        res.connected = comps_linked(ca, cb);
        res.comp_a    = ca;
        res.comp_b    = cb;
        res.merged    = COUNT_W'(merged_total);
        res.labels    = LABEL_W'(label_total);
    endtask

    always @(posedge clk)
    begin
        tracker_result_t res;
        tracker_result_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++) node_comp[i] = NO_COMP;
            for (int i = 0; i < COMPS; i++) comp_group[i] = NO_COMP;
            for (int i = 0; i < COMPS; i++) merged_ids[i] = '0;
            merged_total = 0;
            last_comp    = 0;
            label_total  = 0;
            fail_count   = 0;
            pending      = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_step(command, int'(node_a) % NODES, int'(node_b) % NODES, res);
                expected_results.push_back(res);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status)
                        report($sformatf("status %b, expected %b", status, exp_res.status));
                    if (connected !== exp_res.connected)
                        report($sformatf("connected %b, expected %b",
                                         connected, exp_res.connected));
                    if (comp_of_a !== exp_res.comp_a)
                        report($sformatf("comp_of_a %0d, expected %0d",
                                         comp_of_a, exp_res.comp_a));
                    if (comp_of_b !== exp_res.comp_b)
                        report($sformatf("comp_of_b %0d, expected %0d",
                                         comp_of_b, exp_res.comp_b));
                    if (merged_count !== exp_res.merged)
                        report($sformatf("merged_count %0d, expected %0d",
                                         merged_count, exp_res.merged));
                    if (labelled_count !== exp_res.labels)
                        report($sformatf("labelled_count %0d, expected %0d",
                                         labelled_count, exp_res.labels));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

### tb/tb_top.sv
// Top of the component tracker testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ict_pkg::*;

    // Longest quiet stretch: the clearing pass after reset, a join walking the
    // whole merged ring and the longest drawn stall, taken several times over.
    localparam int QUIET_LIMIT = 6000;
    // Long enough for any item to drain, a join that walks the whole ring included.
    localparam int DRAIN_CYCLES = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  command;
    logic [NODE_IN_W-1:0]  node_a;
    logic [NODE_IN_W-1:0]  node_b;
    logic                  out_valid;
    logic                  out_stall;
    logic                  status;
    logic                  connected;
    logic signed [COMP_OUT_W-1:0] comp_of_a;
    logic signed [COMP_OUT_W-1:0] comp_of_b;
    logic [COUNT_W-1:0]    merged_count;
    logic [LABEL_W-1:0]    labelled_count;
    int                    fail_count;
    int                    pending;
    int                    quiet_cycles = 0;
    // When set, both sides run with no idle cycles for a while.
    logic                  no_idle;

    incremental_component_tracker_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .node_a         (node_a),
        .node_b         (node_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .connected      (connected),
        .comp_of_a      (comp_of_a),
        .comp_of_b      (comp_of_b),
        .merged_count   (merged_count),
        .labelled_count (labelled_count)
    );

    ict_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .node_a         (node_a),
        .node_b         (node_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .connected      (connected),
        .comp_of_a      (comp_of_a),
        .comp_of_b      (comp_of_b),
        .merged_count   (merged_count),
        .labelled_count (labelled_count),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Draws an idle count for one beat; zero throughout a no-idle stretch.
    function automatic int idle_draw();
        return no_idle ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Sends one beat. The valid is dropped only when a gap is drawn, so a
    // back-to-back beat keeps it high without a lower-and-raise in one step.
    // The stall is stable between edges, so seeing it low at a falling edge
    // means the beat is taken at the next rising edge.
    task automatic send_beat(input logic cmd, input int a, input int b);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        node_a   <= NODE_IN_W'(a);
        node_b   <= NODE_IN_W'(b);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    // Random beats over a window of node ids; add_pct sets the share of edges.
    task automatic random_beats(input int count, input int window, input int add_pct);
        for (int i = 0; i < count; i++)
        begin
            if (i % 120 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_beat(($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_QUERY,
                      $urandom_range(0, window - 1), $urandom_range(0, window - 1));
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off each result by a fresh random count of cycles.
    initial
    begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = idle_draw();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(negedge clk);
            while (!out_valid) @(negedge clk);
            @(posedge clk);
        end
    end

    // Watchdog: ends the run if nothing is accepted for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_ADD;
        node_a        = '0;
        node_b        = '0;
        no_idle       = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed beats: unlabelled queries, fresh ids, neighbour labels, joins.
        send_beat(CMD_QUERY, 0, 0);       // unlabelled node with itself
        send_beat(CMD_ADD, 0, 0);         // one node gets a fresh id twice
        send_beat(CMD_ADD, 1023, 512);    // fresh id at the top of the range
        send_beat(CMD_QUERY, 1023, 512);
        send_beat(CMD_ADD, 1, 0);         // a takes its neighbour's id
        send_beat(CMD_ADD, 1023, 2);      // b takes its neighbour's id
        send_beat(CMD_ADD, 3, 4);
        send_beat(CMD_QUERY, 0, 1023);    // labelled but not joined
        send_beat(CMD_ADD, 0, 1023);      // first join
        send_beat(CMD_QUERY, 1, 2);
        send_beat(CMD_ADD, 4, 512);       // join into an existing group
        send_beat(CMD_ADD, 3, 0);         // already connected, no change
        send_beat(CMD_QUERY, 3, 1);
        send_beat(CMD_ADD, 5, 6);
        send_beat(CMD_ADD, 7, 8);
        send_beat(CMD_ADD, 5, 7);         // join of two ungrouped components
        send_beat(CMD_ADD, 8, 0);         // join two groups
        send_beat(CMD_QUERY, 6, 3);
        send_beat(CMD_QUERY, 9, 1022);

        // A small node window fills up fast and gives many joins.
        random_beats(500, 64, 75);

        // Let the block drain completely before changing the traffic mix.
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);

        // Full range of ids, so every bit of both node fields toggles.
        random_beats(250, 1024, 60);

        // Sweep every node as a self-edge; the remaining fresh ids run out and
        // the later fresh requests report a full pool.
        for (int n = 0; n < 1024; n++)
            send_beat(CMD_ADD, n, n);
        send_beat(CMD_ADD, 1023, 0);
        random_beats(60, 1024, 50);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/ict_pkg.sv
rtl/ict_cell.sv
rtl/ict_chain.sv
rtl/incremental_component_tracker_unit.sv
rtl/ict_checker.sv
tb/ict_checker.sv
tb/tb_top.sv
